/* rtl/core/c3dc_pkg.sv */
package c3dc_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int Planes    = 3;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int PixW      = 8 * Planes;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int SumW      = 20;
  localparam int DivSteps  = SumW;

  typedef enum logic [2:0] {
    REG_COEFF_TOP = 3'd0,
    REG_COEFF_MID = 3'd1,
    REG_COEFF_BOT = 3'd2,
    REG_DIVISOR   = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_HEIGHT    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SUM  = 2'd1,
    BK_DIV  = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_t;

  typedef struct packed {
    logic [7:0] chan2;
    logic [7:0] chan1;
    logic [7:0] chan0;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [9:0] pix_row;
    logic [9:0] pix_col;
    logic       last;
  } out_word_t;

  // One classified window, handed from the front to the back.
  typedef struct packed {
    logic [2:0][2:0][PixW-1:0] win;  // [row][col]
    logic [9:0]                row;
    logic [9:0]                col;
    logic                      last;
  } job_t;

  typedef struct packed {
    logic [23:0] top;
    logic [23:0] mid;
    logic [23:0] bot;
    logic [7:0]  div;
  } kern_t;

endpackage

/* rtl/core/c3dc_ram.sv */
module c3dc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/c3dc_front.sv */
module c3dc_front import c3dc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  input  logic [10:0] width_cfg,
  input  logic [10:0] height_cfg,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  // Two phases per pixel: issue the line buffer read, then use the data.
  logic            busy_r, busy_nxt;
  in_word_t        pix_r;
  logic [ColW:0]   col_r, col_nxt, ucol_r;
  logic [RowW:0]   row_r, row_nxt, urow_r;
  logic [ColW:0]   w;
  logic [RowW:0]   h;
  logic [ColW:0]   ccol;
  logic [RowW:0]   crow;
  logic [PixW-1:0] a_q, b_q;
  logic [1:0][2:0][PixW-1:0] wc_r;
  logic            jv_r;
  job_t            job_r;
  logic            we;

  always_comb begin
    if (width_cfg < 11'd3) w = (ColW+1)'(3);
    else if (width_cfg > 11'(MaxWidth)) w = (ColW+1)'(MaxWidth);
    else w = (ColW+1)'(width_cfg);
    if (height_cfg < 11'd3) h = (RowW+1)'(3);
    else if (height_cfg > 11'(MaxHeight)) h = (RowW+1)'(MaxHeight);
    else h = (RowW+1)'(height_cfg);
    ccol = col_r;
    crow = row_r;
    if (ccol >= w) begin
      ccol = '0;
      crow = crow + 1'b1;
    end
    if (crow >= h) crow = '0;
  end

  assign in_ready = !busy_r && !jv_r;
  assign we = busy_r;

  c3dc_ram #(.Width(PixW), .Depth(MaxWidth)) u_lba (
    .clk(clk), .we(we), .waddr(ucol_r[ColW-1:0]), .wdata(pix_r),
    .raddr(ccol[ColW-1:0]), .rdata(a_q)
  );
  c3dc_ram #(.Width(PixW), .Depth(MaxWidth)) u_lbb (
    .clk(clk), .we(we), .waddr(ucol_r[ColW-1:0]), .wdata(a_q),
    .raddr(ccol[ColW-1:0]), .rdata(b_q)
  );

  always_comb begin
    busy_nxt = busy_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_valid && in_ready) begin
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      busy_nxt = 1'b0;
      col_nxt = ucol_r + 1'b1;
      row_nxt = urow_r;
      if (col_nxt >= w) begin
        col_nxt = '0;
        row_nxt = urow_r + 1'b1;
        if (row_nxt >= h) row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
      jv_r   <= 1'b0;
      wc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      if (jv_r && job_ready) jv_r <= 1'b0;
      if (in_valid && in_ready) begin
        pix_r  <= in_data;
        ucol_r <= ccol;
        urow_r <= crow;
      end
      if (busy_r) begin
        wc_r[0] <= wc_r[1];
        wc_r[1] <= {pix_r, a_q, b_q};
        if (urow_r >= (RowW+1)'(2) && ucol_r >= (ColW+1)'(2)) begin
          jv_r <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            job_r.win[i][0] <= wc_r[0][i];
            job_r.win[i][1] <= wc_r[1][i];
          end
          job_r.win[0][2] <= b_q;
          job_r.win[1][2] <= a_q;
          job_r.win[2][2] <= pix_r;
          job_r.row  <= 10'(urow_r - 1'b1);
          job_r.col  <= 10'(ucol_r - 1'b1);
          job_r.last <= (urow_r == h - 1'b1) && (ucol_r == w - 1'b1);
        end
      end
    end
  end

  assign job_valid = jv_r;
  assign job = job_r;

  // wc_r index 0 holds row b (top), packed as {cur,a,b} so [0]=b.
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |=> !busy_r)
    else $error("front busy for two cycles");
  assert property (@(posedge clk) disable iff (!rst_n) jv_r |-> !in_ready)
    else $error("front took a pixel with a job pending");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !in_ready)
    else $error("front took a pixel while busy");

endmodule

/* rtl/core/c3dc_queue.sv */
module c3dc_queue import c3dc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t           q_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;
  logic push, pop;

  assign push_ready = cnt_r != (QPtrW+1)'(QDepth);
  assign pop_valid  = cnt_r != '0;
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;
  assign pop_job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_job;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (QPtrW+1)'(QDepth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count slip");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == '0) |-> !pop)
    else $error("queue underflow");

endmodule

/* rtl/core/c3dc_back.sv */
module c3dc_back import c3dc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  input  kern_t     kern,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // Sums one kernel row per cycle (three multipliers per plane), then
  // divides all planes with one restoring-division step per cycle.
  bk_state_t st_r, st_nxt;
  job_t      job_r;
  logic [1:0] k_r;
  logic [4:0] d_r;
  logic signed [SumW-1:0] acc_r [Planes];
  logic [SumW-1:0] q_r [Planes];
  logic [8:0]      rem_r [Planes];
  logic            neg_r [Planes];
  logic [7:0]      res_r [Planes];
  logic            ov_r;
  logic [23:0]     crow;
  logic [7:0]      dv;

  assign dv = (kern.div == 8'd0) ? 8'd1 : kern.div;

  always_comb begin
    case (k_r)
      2'd0:    crow = kern.top;
      2'd1:    crow = kern.mid;
      default: crow = kern.bot;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (job_valid) st_nxt = BK_SUM;
      BK_SUM:  if (k_r == 2'd2) st_nxt = (dv == 8'd1) ? BK_OUT : BK_DIV;
      BK_DIV:  if (d_r == 5'(DivSteps - 1)) st_nxt = BK_OUT;
      BK_OUT:  if (out_ready) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  assign job_ready = st_r == BK_IDLE;
  assign out_valid = st_r == BK_OUT;

  function automatic logic [7:0] clamp(input logic signed [SumW-1:0] s);
    if (s > 255) return 8'd255;
    if (s < 0) return 8'd0;
    return s[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    case (st_r)
      BK_IDLE: begin
        job_r <= job;
        k_r <= 2'd0;
        for (int p = 0; p < Planes; p++) acc_r[p] <= '0;
      end
      BK_SUM: begin
        for (int p = 0; p < Planes; p++) begin
          logic signed [SumW-1:0] t;
          t = acc_r[p];
          for (int c = 0; c < 3; c++) begin
            t = t + $signed({1'b0, job_r.win[k_r][c][8*p +: 8]}) *
                    $signed(crow[8*c +: 8]);
          end
          acc_r[p] <= t;
          if (k_r == 2'd2) begin
            neg_r[p] <= t[SumW-1];
            q_r[p]   <= t[SumW-1] ? SumW'(-t) : SumW'(t);
            rem_r[p] <= '0;
            res_r[p] <= clamp(t);
          end
        end
        k_r <= k_r + 1'b1;
        d_r <= '0;
      end
      BK_DIV: begin
        for (int p = 0; p < Planes; p++) begin
          logic [8:0] r;
          logic [SumW-1:0] q;
          r = {rem_r[p][7:0], q_r[p][SumW-1]};
          q = {q_r[p][SumW-2:0], 1'b0};
          if (r >= {1'b0, dv}) begin
            r = r - {1'b0, dv};
            q[0] = 1'b1;
          end
          rem_r[p] <= r;
          q_r[p] <= q;
          if (d_r == 5'(DivSteps - 1)) begin
            if (neg_r[p]) res_r[p] <= 8'd0;
            else res_r[p] <= (q > 255) ? 8'd255 : q[7:0];
          end
        end
        d_r <= d_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_data.out0 = res_r[0];
  assign out_data.out1 = res_r[1];
  assign out_data.out2 = res_r[2];
  assign out_data.pix_row = job_r.row;
  assign out_data.pix_col = job_r.col;
  assign out_data.last = job_r.last;

  assert property (@(posedge clk) disable iff (!rst_n) (st_r == BK_SUM) |-> k_r <= 2'd2)
    else $error("row counter out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n) job_ready |-> !out_valid)
    else $error("back took a job with a result pending");

endmodule

/* rtl/core/conv3x3_divide_clamp.sv */
// The front takes a pixel, reads the line buffers, then writes them; an interior
// pixel's window word is held until the queue takes it, and no new pixel is taken
// meanwhile. The back sums, divides unless the divisor is 0 or 1, clamps, and takes
// no new window until its result has been accepted. Reset (synchronous, rst_n low)
// clears counters, window and queue, and loads the configuration defaults.
module conv3x3_divide_clamp import c3dc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // Configuration registers; writes are taken at any time.
  kern_t       kern_r;
  logic [10:0] width_r, height_r;
  logic        fv, fr, qv, qr;
  job_t        fj, qj;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r.top <= 24'h0;
      kern_r.mid <= 24'h010000;
      kern_r.bot <= 24'h0;
      kern_r.div <= 8'd1;
      width_r    <= 11'd1024;
      height_r   <= 11'd1024;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEFF_TOP: kern_r.top <= cfg_data;
        REG_COEFF_MID: kern_r.mid <= cfg_data;
        REG_COEFF_BOT: kern_r.bot <= cfg_data;
        REG_DIVISOR:   kern_r.div <= cfg_data[7:0];
        REG_WIDTH:     width_r <= cfg_data[10:0];
        REG_HEIGHT:    height_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Front: line buffers, window and position counters.
  c3dc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .width_cfg(width_r), .height_cfg(height_r),
    .job_valid(fv), .job_ready(fr), .job(fj)
  );

  // Queue of classified windows.
  c3dc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_valid(fv), .push_ready(fr), .push_job(fj),
    .pop_valid(qv), .pop_ready(qr), .pop_job(qj)
  );

  // Back: multiply-accumulate, divide, clamp, hold the result.
  c3dc_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(qv), .job_ready(qr), .job(qj),
    .kern(kern_r), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

/* bench/conv3x3_divide_clamp_test.sv */
`timescale 1ns / 1ps

module conv3x3_divide_clamp_test;
  import c3dc_pkg::*;

  // Generous bound on the whole run; a healthy run stays far below it.
  localparam int CycleLimit = 3000000;
  // Cycles allowed for the back end to settle after the last expected word.
  localparam int SettleCycles = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  conv3x3_divide_clamp u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Shadow copies of the configuration registers, updated when a write is accepted.
  logic [23:0] kern_top, kern_mid, kern_bot;
  logic [7:0]  div_reg;
  logic [10:0] width_reg, height_reg;

  // Filter state mirrored from the block: two line buffers (row above, two rows
  // above), the two window columns left of the current pixel, and the position
  // of the next pixel in the raster.
  logic [23:0] line_above [MaxWidth];
  logic [23:0] line_above2 [MaxWidth];
  logic [23:0] win_left [3];
  logic [23:0] win_mid [3];
  int          pos_row, pos_col;

  out_word_t   pending_pixels[$];
  int          errors;
  int          cycles;
  int          rand_items;
  bit          no_idle;

  typedef struct {
    bit          is_cfg;
    cfg_reg_t    idx;
    logic [23:0] data;
    in_word_t    px;
    bit          has_exp;
    out_word_t   exp;
  } stim_row_t;

  stim_row_t directed[$];

  // A width or height register outside 3..max acts as the nearest bound.
  function automatic int eff_size(int v, int maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int kern_tap(logic [23:0] rowreg, int k);
    logic signed [7:0] b;
    b = rowreg[8*k +: 8];
    return b;
  endfunction

  // Advances the mirrored filter by one pixel and yields the filtered word when
  // the pixel completes the 3x3 window of an interior pixel.
  task automatic filter_pixel(input in_word_t px, output bit has, output out_word_t o);
    int w, h, d, s, a;
    logic [23:0] colv [3];
    logic [23:0] kr [3];
    logic [7:0]  pv [3];
    w = eff_size(width_reg, MaxWidth);
    h = eff_size(height_reg, MaxHeight);
    // A shrink of the size registers mid-image restarts the counters here.
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    colv[0] = line_above2[pos_col];
    colv[1] = line_above[pos_col];
    colv[2] = px;
    line_above2[pos_col] = line_above[pos_col];
    line_above[pos_col] = px;
    kr[0] = kern_top;
    kr[1] = kern_mid;
    kr[2] = kern_bot;
    has = 1'b0;
    o = '0;
    if (pos_row >= 2 && pos_col >= 2) begin
      // A zero divisor behaves like one, so the sum passes unchanged.
      d = (div_reg == 8'd0) ? 1 : int'(div_reg);
      for (int p = 0; p < 3; p++) begin
        s = 0;
        for (int i = 0; i < 3; i++) begin
          a = win_left[i][8*p +: 8];
          s += a * kern_tap(kr[i], 0);
          a = win_mid[i][8*p +: 8];
          s += a * kern_tap(kr[i], 1);
          a = colv[i][8*p +: 8];
          s += a * kern_tap(kr[i], 2);
        end
        // SystemVerilog integer division truncates toward zero, as required.
        if (d != 1) s = s / d;
        if (s > 255) s = 255;
        if (s < 0) s = 0;
        pv[p] = s[7:0];
      end
      o.out0 = pv[0];
      o.out1 = pv[1];
      o.out2 = pv[2];
      o.pix_row = 10'(pos_row - 1);
      o.pix_col = 10'(pos_col - 1);
      o.last = (pos_row == h - 1) && (pos_col == w - 1);
      has = 1'b1;
    end
    win_left = win_mid;
    win_mid = colv;
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  // Mostly short gaps, a few long ones, none at all during a burst stretch.
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one pixel word. Called and returning at a falling edge; in_valid is
  // left high so that back-to-back words keep the channel busy.
  task automatic send_pixel(input in_word_t px, input bit typed, input out_word_t typed_exp);
    int        g;
    bit        has;
    out_word_t o;
    g = idle_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data = px;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_pixel(px, has, o);
    if (typed) pending_pixels.push_back(typed_exp);
    else if (has) pending_pixels.push_back(o);
    @(negedge clk);
  endtask

  // Register writes only happen with the filter idle: every expected word has
  // come back and the back end has had time to retire border-only work.
  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_COEFF_TOP: kern_top = val;
      REG_COEFF_MID: kern_mid = val;
      REG_COEFF_BOT: kern_bot = val;
      REG_DIVISOR:   div_reg = val[7:0];
      REG_WIDTH:     width_reg = val[10:0];
      REG_HEIGHT:    height_reg = val[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_word_t rand_pixel();
    in_word_t px;
    px = 24'($urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 9) == 0) px.chan0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 9) == 0) px.chan1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 9) == 0) px.chan2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return px;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 299) == 0) no_idle = ~no_idle;
      send_pixel(rand_pixel(), 1'b0, '0);
      rand_items++;
    end
  endtask

  // Pads the current image out to its end, so that a later width increase
  // never reads a line buffer entry that was not written.
  task automatic finish_image();
    while (pos_row != 0 || pos_col != 0) send_random(1);
  endtask

  function automatic logic [23:0] rand_kernel_row();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h7F7F7F;
    if (r == 1) return 24'h808080;
    if (r == 2) return 24'h000000;
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  task automatic random_phase();
    int mode, wr, hr, w, h, per_img, part, r;
    finish_image();
    mode = $urandom_range(0, 99);
    if (mode < 90) begin
      wr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
    end else if (mode < 95) begin
      // Wide frames exercise the upper width bits; keep them only three rows tall.
      wr = $urandom_range(64, 400);
      hr = $urandom_range(0, 3);
    end else begin
      wr = $urandom_range(0, 3);
      hr = $urandom_range(0, 2047);
    end
    write_reg(REG_COEFF_TOP, rand_kernel_row());
    write_reg(REG_COEFF_MID, rand_kernel_row());
    write_reg(REG_COEFF_BOT, rand_kernel_row());
    r = $urandom_range(0, 9);
    write_reg(REG_DIVISOR, (r == 0) ? 24'd0 : (r == 1) ? 24'd1 : (r == 2) ? 24'd255 :
              24'($urandom_range(2, 40)));
    write_reg(REG_WIDTH, 24'(wr));
    write_reg(REG_HEIGHT, 24'(hr));
    w = eff_size(wr, MaxWidth);
    h = eff_size(hr, MaxHeight);
    per_img = w * h;
    if (mode >= 95 || (mode < 90 && $urandom_range(0, 3) == 0)) begin
      // Change the frame size in the middle of an image, then finish it.
      part = w * $urandom_range(2, (h > 30) ? 30 : h) + $urandom_range(0, w - 1);
      if (part >= per_img) part = per_img - 1;
      send_random(part);
      if ($urandom_range(0, 1) == 0) write_reg(REG_WIDTH, 24'($urandom_range(3, w)));
      else write_reg(REG_HEIGHT, 24'($urandom_range(0, 12)));
      finish_image();
    end else begin
      send_random(per_img * ((mode < 90) ? $urandom_range(1, 3) : 1));
    end
  endtask

  task automatic add_cfg(input cfg_reg_t idx, input logic [23:0] val);
    stim_row_t s;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = val;
    s.px = '0;
    s.has_exp = 1'b0;
    s.exp = '0;
    directed.push_back(s);
  endtask

  task automatic add_pixel(input in_word_t px, input bit typed, input out_word_t exp);
    stim_row_t s;
    s.is_cfg = 1'b0;
    s.idx = REG_COEFF_TOP;
    s.data = '0;
    s.px = px;
    s.has_exp = typed;
    s.exp = exp;
    directed.push_back(s);
  endtask

  task automatic report(input string field, input logic [9:0] exp, input logic [9:0] act);
    $display("%0t: mismatch on %s, expected %h, actual %h", $time, field, exp, act);
    errors++;
  endtask

  // Result side: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (out_data.out0 !== e.out0) report("out0", 10'(e.out0), 10'(out_data.out0));
        if (out_data.out1 !== e.out1) report("out1", 10'(e.out1), 10'(out_data.out1));
        if (out_data.out2 !== e.out2) report("out2", 10'(e.out2), 10'(out_data.out2));
        if (out_data.pix_row !== e.pix_row) report("pix_row", e.pix_row, out_data.pix_row);
        if (out_data.pix_col !== e.pix_col) report("pix_col", e.pix_col, out_data.pix_col);
        if (out_data.last !== e.last) report("last", 10'(e.last), 10'(out_data.last));
      end
    end
  end

  // Receiver stalls, changed only at the falling edge.
  int out_gap;
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= idle_len();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("conv3x3_divide_clamp regression: fail");
      $finish;
    end
  end

  initial begin
    in_word_t  px;
    out_word_t ex;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_gap = 0;
    errors = 0;
    cycles = 0;
    rand_items = 0;
    no_idle = 1'b0;
    kern_top = 24'h000000;
    kern_mid = 24'h010000;
    kern_bot = 24'h000000;
    div_reg = 8'd1;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    pos_row = 0;
    pos_col = 0;
    for (int i = 0; i < 3; i++) begin
      win_left[i] = '0;
      win_mid[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The reset kernel has a single tap of one, on the right of the middle row:
    // the one interior pixel of a 3x3 frame returns the pixel to its right
    // (row 1, column 2) unchanged, and it is the last one.
    add_cfg(REG_WIDTH, 24'd3);
    add_cfg(REG_HEIGHT, 24'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 5) begin
        px.chan2 = 8'h80;
        px.chan1 = 8'h00;
        px.chan0 = 8'hFF;
      end else begin
        px = rand_pixel();
      end
      ex = '{out0: 8'hFF, out1: 8'h00, out2: 8'h80, pix_row: 10'd1, pix_col: 10'd1,
             last: 1'b1};
      add_pixel(px, i == 8, ex);
    end
    // Largest positive taps on full-scale pixels saturate high.
    add_cfg(REG_COEFF_TOP, 24'h7F7F7F);
    add_cfg(REG_COEFF_MID, 24'h7F7F7F);
    add_cfg(REG_COEFF_BOT, 24'h7F7F7F);
    for (int i = 0; i < 9; i++) begin
      ex = '{out0: 8'hFF, out1: 8'hFF, out2: 8'hFF, pix_row: 10'd1, pix_col: 10'd1,
             last: 1'b1};
      add_pixel(24'hFFFFFF, i == 8, ex);
    end
    // Most negative taps with a zero divisor saturate low.
    add_cfg(REG_COEFF_TOP, 24'h808080);
    add_cfg(REG_COEFF_MID, 24'h808080);
    add_cfg(REG_COEFF_BOT, 24'h808080);
    add_cfg(REG_DIVISOR, 24'd0);
    for (int i = 0; i < 9; i++) begin
      ex = '{out0: 8'h00, out1: 8'h00, out2: 8'h00, pix_row: 10'd1, pix_col: 10'd1,
             last: 1'b1};
      add_pixel((i % 2) ? 24'hFFFFFF : 24'h010203, i == 8, ex);
    end
    // Positive top row, negative others, largest divisor, 4x4 frame; predicted.
    add_cfg(REG_COEFF_TOP, 24'h7F7F7F);
    add_cfg(REG_DIVISOR, 24'd255);
    add_cfg(REG_WIDTH, 24'd4);
    add_cfg(REG_HEIGHT, 24'd4);
    for (int i = 0; i < 16; i++) add_pixel(rand_pixel(), 1'b0, '0);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].data);
      else send_pixel(directed[i].px, directed[i].has_exp, directed[i].exp);
    end
    in_valid = 1'b0;

    while (rand_items < 1900) random_phase();
    finish_image();
    in_valid = 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("conv3x3_divide_clamp regression: pass");
    end else begin
      $display("conv3x3_divide_clamp regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/c3dc_pkg.sv
rtl/core/c3dc_ram.sv
rtl/core/c3dc_front.sv
rtl/core/c3dc_queue.sv
rtl/core/c3dc_back.sv
rtl/core/conv3x3_divide_clamp.sv
bench/conv3x3_divide_clamp_test.sv
